// File: src/sum_checked_frame_parser_top_assert.svh
// Assertion macros used by the checker file of the frame parser.
`ifndef SUM_CHECKED_FRAME_PARSER_TOP_ASSERT_SVH
`define SUM_CHECKED_FRAME_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SCFP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SCFP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/scfp_pkg.sv
// Types and constants shared by the sum-checked frame parser modules.
`default_nettype none
package scfp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned KIND_W = 2;

    localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACCEPT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MISMATCH = 2'd2;

    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'd170;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] frame_id;
        logic [BYTE_W-1:0] data_index;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] frame_len;
        logic              last;
    } result_t;

endpackage
`default_nettype wire

// File: src/scfp_parser.sv
// Frame parser state machine: decodes one received byte per accepted word.
`default_nettype none
module scfp_parser (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_valid,
    input  wire logic [scfp_pkg::BYTE_W-1:0] cfg_data,
    input  wire logic                      in_accept,
    input  wire logic [scfp_pkg::BYTE_W-1:0] rx_byte,
    output logic                           res_valid,
    output scfp_pkg::result_t              res
);

    localparam logic [1:0] PH_SYNC = 2'd0;
    localparam logic [1:0] PH_ID   = 2'd1;
    localparam logic [1:0] PH_LEN  = 2'd2;
    localparam logic [1:0] PH_DATA = 2'd3;

    logic [1:0]                  phase_reg, phase_next;
    logic [scfp_pkg::BYTE_W-1:0] sync_reg;
    logic [scfp_pkg::BYTE_W-1:0] id_reg, id_next;
    logic [scfp_pkg::BYTE_W-1:0] len_reg, len_next;
    logic [scfp_pkg::BYTE_W-1:0] idx_reg, idx_next;
    logic [scfp_pkg::BYTE_W-1:0] sum_reg, sum_next;

    always_comb begin
        phase_next     = phase_reg;
        id_next        = id_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        res_valid      = 1'b0;
        res.kind       = scfp_pkg::KIND_PAYLOAD;
        res.frame_id   = id_reg;
        res.data_index = idx_reg;
        res.data_byte  = rx_byte;
        res.frame_len  = len_reg;
        res.last       = 1'b0;
        if (in_accept) begin
            case (phase_reg)
                PH_SYNC: begin
                    if (rx_byte == sync_reg) begin
                        phase_next = PH_ID;
                        id_next    = '0;
                        len_next   = '0;
                        idx_next   = '0;
                        sum_next   = rx_byte;
                    end
                end
                PH_ID: begin
                    id_next    = rx_byte;
                    sum_next   = sum_reg + rx_byte;
                    phase_next = PH_LEN;
                end
                PH_LEN: begin
                    len_next   = rx_byte;
                    idx_next   = '0;
                    sum_next   = sum_reg + rx_byte;
                    phase_next = PH_DATA;
                end
                PH_DATA: begin
                    res_valid = 1'b1;
                    if (idx_reg < len_reg) begin
                        sum_next = sum_reg + rx_byte;
                        idx_next = idx_reg + 8'd1;
                    end else begin
                        // The checksum byte closes the frame whatever its verdict.
                        res.kind       = (rx_byte == sum_reg) ? scfp_pkg::KIND_ACCEPT
                                                              : scfp_pkg::KIND_MISMATCH;
                        res.data_index = '0;
                        res.data_byte  = '0;
                        res.last       = 1'b1;
                        phase_next     = PH_SYNC;
                    end
                end
                default: begin
                    phase_next = PH_SYNC;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SYNC;
            sync_reg  <= scfp_pkg::SYNC_RESET;
            id_reg    <= '0;
            len_reg   <= '0;
            idx_reg   <= '0;
            sum_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
            if (cfg_valid) begin
                sync_reg <= cfg_data;
            end
        end
    end

endmodule
`default_nettype wire

// File: src/scfp_out_buf.sv
// Output register with a skid stage, so input ready never depends on output ready.
`default_nettype none
module scfp_out_buf (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  scfp_pkg::result_t      push_data,
    output logic                   space,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output scfp_pkg::result_t      out_data
);

    logic              main_valid_reg, main_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    scfp_pkg::result_t main_reg, main_next;
    scfp_pkg::result_t skid_reg, skid_next;
    logic              pop;

    assign pop       = main_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end else begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule
`default_nettype wire

// File: src/sum_checked_frame_parser_top.sv
// Sum-checked frame parser: takes one received byte per word and deframes
// sync, id, length, payload and checksum, passing each payload byte out as it
// arrives and closing each frame with an accepted or mismatch word marked by
// m_tlast. Bytes outside a frame are dropped until the sync byte is seen. The
// parser takes one byte per clock cycle while s_tready is high; each byte is
// decoded by one compare, one 8-bit add and one counter update ahead of the
// output register, which registers each result for m_tvalid. A two-entry output
// stage lets s_tready stay high while one result waits, and s_tready drops
// only once two results are held. The sync value is written through the cfg
// channel, which is always ready.
`default_nettype none
module sum_checked_frame_parser_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data,   // sync_byte
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,    // frame_id, data_index, data_byte, frame_len
    output logic [1:0]       m_tuser,    // kind
    output logic             m_tlast     // last
);

    logic              in_accept;
    logic              res_valid;
    scfp_pkg::result_t res;
    scfp_pkg::result_t out_res;

    assign cfg_ready = 1'b1;
    assign in_accept = s_tvalid && s_tready;

    scfp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_accept (in_accept),
        .rx_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    scfp_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .space     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {out_res.frame_len, out_res.data_byte, out_res.data_index,
                      out_res.frame_id};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule
`default_nettype wire

// File: src/scfp_checker.sv
// Port-level checks on the frame parser, bound to its top level.
`default_nettype none
`include "sum_checked_frame_parser_top_assert.svh"
module scfp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    // The verdict word, and only it, carries last.
    `SCFP_ASSERT_IMP(a_last_kind, aclk, aresetn, m_tvalid, m_tlast == (m_tuser != scfp_pkg::KIND_PAYLOAD), "last does not match kind")

    // A verdict word carries zero index and zero data byte.
    `SCFP_ASSERT_IMP(a_verdict_zero, aclk, aresetn, m_tvalid && m_tlast, m_tdata[23:8] == 16'd0, "verdict word has non-zero index or data")

    // A payload index always lies below the announced length.
    `SCFP_ASSERT_IMP(a_index_range, aclk, aresetn, m_tvalid && !m_tlast, m_tdata[15:8] < m_tdata[31:24], "payload index not below frame length")

    // A stalled result word holds until taken.
    `SCFP_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result word changed")

    // The input is only held off while result words are waiting.
    `SCFP_ASSERT_IMP(a_stall_full, aclk, aresetn, !s_tready, m_tvalid, "input stalled with no result word waiting")

endmodule

bind sum_checked_frame_parser_top scfp_checker u_scfp_checker (.*);
`default_nettype wire

// File: dv/tb_sum_checked_frame_parser_top.sv
// Self-checking testbench for the sum-checked frame parser top level.
module tb_sum_checked_frame_parser_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE      = 4;     // cycles allowed for the output stage to empty
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int QUIET_LIMIT = 2000;  // cycles without any handshake before giving up
    localparam int MAX_REPORTS = 10;

    typedef enum logic [1:0] {WAIT_SYNC, WAIT_ID, WAIT_LEN, IN_BODY} parse_phase_e;
    typedef enum int {FILL_RANDOM, FILL_EXTREME, FILL_SYNC} fill_e;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // Parser copy kept by the testbench.
    parse_phase_e prs_phase = WAIT_SYNC;
    logic [7:0]   prs_sync  = scfp_pkg::SYNC_RESET;
    logic [7:0]   prs_id    = '0;
    logic [7:0]   prs_len   = '0;
    logic [7:0]   prs_count = '0;
    logic [7:0]   prs_sum   = '0;

    logic [7:0]          pend_bytes[$];
    scfp_pkg::result_t   exp_results[$];

    logic [7:0] stim_sync    = scfp_pkg::SYNC_RESET;
    int         in_idle_pct  = 37;
    int         out_idle_pct = 37;
    int         stall_req    = 0;
    int         stall_seen   = 0;
    int         hold_left    = 0;
    int         cfg_writes   = 0;
    int         err_cnt      = 0;
    int         quiet        = 0;
    bit         s_taken      = 1'b0;

    sum_checked_frame_parser_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Advances the parser copy by one received byte and queues any result it causes.
    task automatic parse_byte(input logic [7:0] c);
        scfp_pkg::result_t r;
        r = '0;
        r.frame_id  = prs_id;
        r.frame_len = prs_len;
        case (prs_phase)
            WAIT_SYNC: begin
                if (c == prs_sync) begin
                    prs_phase = WAIT_ID;
                    prs_id    = '0;
                    prs_len   = '0;
                    prs_count = '0;
                    prs_sum   = c;
                end
            end
            WAIT_ID: begin
                prs_id    = c;
                prs_sum   = prs_sum + c;
                prs_phase = WAIT_LEN;
            end
            WAIT_LEN: begin
                prs_len   = c;
                prs_count = '0;
                prs_sum   = prs_sum + c;
                prs_phase = IN_BODY;
            end
            default: begin
                if (prs_count < prs_len) begin
                    r.kind       = scfp_pkg::KIND_PAYLOAD;
                    r.data_index = prs_count;
                    r.data_byte  = c;
                    r.last       = 1'b0;
                    exp_results.push_back(r);
                    prs_sum   = prs_sum + c;
                    prs_count = prs_count + 8'd1;
                end else begin
                    r.kind = (c == prs_sum) ? scfp_pkg::KIND_ACCEPT : scfp_pkg::KIND_MISMATCH;
                    r.last = 1'b1;
                    exp_results.push_back(r);
                    prs_phase = WAIT_SYNC;
                end
            end
        endcase
    endtask

    // Driver: offers the next pending byte once the current word has gone.
    always @(negedge aclk) begin
        if (!s_tvalid || s_taken) begin
            if (pend_bytes.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
                s_tdata  <= pend_bytes.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure plus a long hold-off on request.
    always @(negedge aclk) begin
        if (stall_req != stall_seen) begin
            stall_seen = stall_req;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    // Monitor: tracks register writes and accepted bytes, checks every result word.
    always @(posedge aclk) begin
        scfp_pkg::result_t got;
        scfp_pkg::result_t want;
        s_taken = 1'b0;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                prs_sync   = cfg_data;
                cfg_writes = cfg_writes + 1;
            end
            s_taken = s_tvalid && s_tready;
            if (s_taken)
                parse_byte(s_tdata);
            if (m_tvalid && m_tready) begin
                got.kind       = m_tuser;
                got.frame_id   = m_tdata[7:0];
                got.data_index = m_tdata[15:8];
                got.data_byte  = m_tdata[23:16];
                got.frame_len  = m_tdata[31:24];
                got.last       = m_tlast;
                if (exp_results.size() == 0) begin
                    if (err_cnt < MAX_REPORTS)
                        $display("unexpected word: kind %0d id %0d idx %0d %s",
                                 got.kind, got.frame_id, got.data_index,
                                 $sformatf("byte %0d len %0d last %0d",
                                           got.data_byte, got.frame_len, got.last));
                    err_cnt = err_cnt + 1;
                end else begin
                    want = exp_results.pop_front();
                    if (got.kind != want.kind || got.frame_id != want.frame_id ||
                        got.data_index != want.data_index ||
                        got.data_byte != want.data_byte ||
                        got.frame_len != want.frame_len || got.last != want.last) begin
                        if (err_cnt < MAX_REPORTS) begin
                            $display("mismatch at %0t: expected kind %0d id %0d idx %0d %s",
                                     $realtime, want.kind, want.frame_id, want.data_index,
                                     $sformatf("byte %0d len %0d last %0d",
                                               want.data_byte, want.frame_len, want.last));
                            $display("    got kind %0d id %0d idx %0d %s",
                                     got.kind, got.frame_id, got.data_index,
                                     $sformatf("byte %0d len %0d last %0d",
                                               got.data_byte, got.frame_len, got.last));
                        end
                        err_cnt = err_cnt + 1;
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which no word moves on any channel.
    always @(posedge aclk) begin
        if (!aresetn || (cfg_valid && cfg_ready) || (s_tvalid && s_tready) ||
            (m_tvalid && m_tready)) begin
            quiet = 0;
        end else begin
            quiet = quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
                $display("tb_sum_checked_frame_parser_top: FAIL");
                $finish;
            end
        end
    end

    // Waits until every byte is taken and every result has arrived, then lets the pipe settle.
    task automatic wait_idle();
        while (pend_bytes.size() != 0 || s_tvalid || exp_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_sync(input logic [7:0] v);
        int seen;
        seen      = cfg_writes;
        stim_sync = v;
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        while (cfg_writes == seen)
            @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_frame(input logic [7:0] sv, input logic [7:0] fid,
                             input logic [7:0] len, input fill_e fill, input bit bad);
        logic [7:0] sum;
        logic [7:0] b;
        sum = sv + fid + len;
        pend_bytes.push_back(sv);
        pend_bytes.push_back(fid);
        pend_bytes.push_back(len);
        for (int i = 0; i < int'(len); i++) begin
            case (fill)
                FILL_RANDOM:  b = 8'($urandom_range(255));
                FILL_EXTREME: b = (i % 2) ? 8'hFF : 8'h00;
                default:      b = sv;
            endcase
            sum = sum + b;
            pend_bytes.push_back(b);
        end
        if (bad)
            sum = sum ^ 8'($urandom_range(255, 1));
        pend_bytes.push_back(sum);
    endtask

    // Feeds non-sync bytes until the parser sits between frames again.
    task automatic drain_frame();
        while (prs_phase != WAIT_SYNC) begin
            pend_bytes.push_back(~stim_sync);
            wait_idle();
        end
    endtask

    // Mostly well-formed frames with random content, some noise and cut-off frames.
    task automatic run_random(input int n);
        int         added;
        int         r;
        int         k;
        logic [7:0] len;
        added = 0;
        while (added < n) begin
            r = $urandom_range(99);
            if (r < 70) begin
                len = 8'($urandom_range(12));
                add_frame(stim_sync, 8'($urandom_range(255)), len,
                          ($urandom_range(9) == 0) ? FILL_EXTREME : FILL_RANDOM,
                          $urandom_range(3) == 0);
                added = added + int'(len) + 4;
            end else if (r < 85) begin
                k = $urandom_range(4, 1);
                repeat (k) pend_bytes.push_back(8'($urandom_range(255)));
            end else begin
                len = 8'($urandom_range(12, 1));
                k   = $urandom_range(int'(len) - 1);
                pend_bytes.push_back(stim_sync);
                pend_bytes.push_back(8'($urandom_range(255)));
                pend_bytes.push_back(len);
                repeat (k) pend_bytes.push_back(8'($urandom_range(255)));
                added = added + k + 3;
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: bytes outside a frame, zero-length frames, extreme payload bytes.
        pend_bytes.push_back(8'h00);
        pend_bytes.push_back(8'hFF);
        pend_bytes.push_back(8'h55);
        add_frame(scfp_pkg::SYNC_RESET, 8'h00, 8'd0, FILL_RANDOM, 1'b0);
        add_frame(scfp_pkg::SYNC_RESET, 8'hFF, 8'd0, FILL_RANDOM, 1'b1);
        add_frame(scfp_pkg::SYNC_RESET, scfp_pkg::SYNC_RESET, 8'd2, FILL_EXTREME, 1'b0);
        wait_idle();

        // The sync value inside a frame is ordinary data.
        write_sync(8'd3);
        add_frame(8'd3, 8'd3, 8'd3, FILL_SYNC, 1'b0);
        // Leave a frame open and change the sync value under it.
        pend_bytes.push_back(8'd3);
        pend_bytes.push_back(8'h11);
        pend_bytes.push_back(8'd2);
        wait_idle();
        write_sync(8'h00);
        run_random(120);
        wait_idle();

        // Receiver holds off while the sender keeps offering a long frame.
        drain_frame();
        in_idle_pct = 0;
        stall_req   = stall_req + 1;
        add_frame(stim_sync, 8'($urandom_range(255)), 8'd40, FILL_RANDOM, 1'b0);
        wait_idle();

        // A stretch with no idling on either side.
        write_sync(8'hFF);
        out_idle_pct = 0;
        run_random(90);
        wait_idle();

        in_idle_pct  = 37;
        out_idle_pct = 37;
        run_random(50);
        wait_idle();
        drain_frame();
        add_frame(stim_sync, 8'($urandom_range(255)), 8'd255, FILL_RANDOM, 1'b0);
        wait_idle();

        write_sync(8'($urandom_range(255)));
        run_random(80);
        wait_idle();

        if (err_cnt == 0 && exp_results.size() == 0) begin
            $display("tb_sum_checked_frame_parser_top: PASS");
        end else begin
            $display("tb_sum_checked_frame_parser_top: FAIL");
        end
        $finish;
    end

endmodule
